### hdl/rcss_pkg.sv
// Package: shared types, codes and constants for the radio channel scan sequencer.
package rcss_pkg;

    localparam int CHANNEL_COUNT_DEF = 13;

    localparam int CH_W    = 4;
    localparam int CNT_W   = 16;
    localparam int TICK_W  = 14;
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 48;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;
    localparam int S_DW    = 88;
    localparam int M_DW    = 56;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_BASE_DWELL      = 3'd0;
    localparam logic [2:0] REG_PROBE_INTERVAL  = 3'd1;
    localparam logic [2:0] REG_DWELL_EXTENSION = 3'd2;
    localparam logic [2:0] REG_ACK_MIN_LENGTH  = 3'd3;
    localparam logic [2:0] REG_PROBE_TYPE_CODE = 3'd4;
    localparam logic [2:0] REG_ACK_TYPE_CODE   = 3'd5;

    localparam logic [TICK_W-1:0] BASE_DWELL_RST      = 14'd100;
    localparam logic [TICK_W-1:0] PROBE_INTERVAL_RST  = 14'd50;
    localparam logic [TICK_W-1:0] DWELL_EXTENSION_RST = 14'd500;
    localparam logic [BYTE_W-1:0] ACK_MIN_LENGTH_RST  = 8'd4;
    localparam logic [BYTE_W-1:0] PROBE_TYPE_CODE_RST = 8'd0;
    localparam logic [BYTE_W-1:0] ACK_TYPE_CODE_RST   = 8'd1;

    // Input item kinds
    localparam logic [1:0] FUNC_START   = 2'd0;
    localparam logic [1:0] FUNC_TICK    = 2'd1;
    localparam logic [1:0] FUNC_SET_RES = 2'd2;
    localparam logic [1:0] FUNC_MESSAGE = 2'd3;

    // Result actions
    localparam logic [1:0] ACT_SET_CHANNEL = 2'd0;
    localparam logic [1:0] ACT_SEND_PROBE  = 2'd1;
    localparam logic [1:0] ACT_FOUND       = 2'd2;
    localparam logic [1:0] ACT_FAILED      = 2'd3;

    // Scan phases
    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_FAST     = 2'd1;
    localparam logic [1:0] PH_WEIGHTED = 2'd2;

    typedef struct packed {
        logic [TICK_W-1:0] base_dwell;
        logic [TICK_W-1:0] probe_interval;
        logic [TICK_W-1:0] dwell_extension;
        logic [BYTE_W-1:0] ack_min_length;
        logic [BYTE_W-1:0] probe_type_code;
        logic [BYTE_W-1:0] ack_type_code;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [BYTE_W-1:0] hint_channel;
        logic              set_ok;
        logic [BYTE_W-1:0] message_type;
        logic [BYTE_W-1:0] message_length;
        logic [BYTE_W-1:0] reported_channel;
        logic [ADDR_W-1:0] sender_address;
    } item_t;

    typedef struct packed {
        logic              valid;
        logic [1:0]        action;
        logic [CH_W-1:0]   channel;
        logic [ADDR_W-1:0] peer_address;
    } result_t;

endpackage

### hdl/radio_channel_scan_sequencer.sv
// Top level: input beat register, scan core, result register and APB config port.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: item fields, tuser: func
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: channel, peer addr; tuser: action
//  apb       in   psel/penable/pwrite, pready   six registers at 4*i
//
// One beat per cycle sustained while m_axis is not stalled; an accepted beat waits in the
// input register until the scan core fires on it, and its result, if any, lands in the
// result register and is offered on m_axis. rst_n clears all scan state and loads register
// defaults. A stalled m_axis holds the result register, which in turn holds the input
// register; s_axis_tready drops only then.
module radio_channel_scan_sequencer
    import rcss_pkg::*;
#(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // hint_channel, set_ok, message_type, message_length, reported_channel,
    // sender_address, zero pad
    input  logic [S_DW-1:0]   s_axis_tdata,
    // func
    input  logic [1:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // channel, peer_address, zero pad
    output logic [M_DW-1:0]   m_axis_tdata,
    // action
    output logic [1:0]        m_axis_tuser
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t res;
    logic    fire;

    rcss_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.func             <= s_axis_tuser;
            in_item_reg.hint_channel     <= s_axis_tdata[7:0];
            in_item_reg.set_ok           <= s_axis_tdata[8];
            in_item_reg.message_type     <= s_axis_tdata[16:9];
            in_item_reg.message_length   <= s_axis_tdata[24:17];
            in_item_reg.reported_channel <= s_axis_tdata[32:25];
            in_item_reg.sender_address   <= s_axis_tdata[80:33];
        end
    end

    rcss_core #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= res.valid;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.action;
    assign m_axis_tdata  = {{(M_DW-ADDR_W-CH_W){1'b0}}, out_reg.peer_address, out_reg.channel};

endmodule

### hdl/rcss_cfg_regs.sv
// APB configuration register file for the scan sequencer.
module rcss_cfg_regs
    import rcss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t        cfg_reg;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[APB_AW-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_dwell      <= BASE_DWELL_RST;
            cfg_reg.probe_interval  <= PROBE_INTERVAL_RST;
            cfg_reg.dwell_extension <= DWELL_EXTENSION_RST;
            cfg_reg.ack_min_length  <= ACK_MIN_LENGTH_RST;
            cfg_reg.probe_type_code <= PROBE_TYPE_CODE_RST;
            cfg_reg.ack_type_code   <= ACK_TYPE_CODE_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_BASE_DWELL:      cfg_reg.base_dwell      <= pwdata[TICK_W-1:0];
                REG_PROBE_INTERVAL:  cfg_reg.probe_interval  <= pwdata[TICK_W-1:0];
                REG_DWELL_EXTENSION: cfg_reg.dwell_extension <= pwdata[TICK_W-1:0];
                REG_ACK_MIN_LENGTH:  cfg_reg.ack_min_length  <= pwdata[BYTE_W-1:0];
                REG_PROBE_TYPE_CODE: cfg_reg.probe_type_code <= pwdata[BYTE_W-1:0];
                REG_ACK_TYPE_CODE:   cfg_reg.ack_type_code   <= pwdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_BASE_DWELL:      prdata = APB_DW'(cfg_reg.base_dwell);
            REG_PROBE_INTERVAL:  prdata = APB_DW'(cfg_reg.probe_interval);
            REG_DWELL_EXTENSION: prdata = APB_DW'(cfg_reg.dwell_extension);
            REG_ACK_MIN_LENGTH:  prdata = APB_DW'(cfg_reg.ack_min_length);
            REG_PROBE_TYPE_CODE: prdata = APB_DW'(cfg_reg.probe_type_code);
            REG_ACK_TYPE_CODE:   prdata = APB_DW'(cfg_reg.ack_type_code);
            default:             prdata = '0;
        endcase
    end

endmodule

### hdl/rcss_core.sv
// Scan state registers and the per-beat next-state and result logic.
module rcss_core
    import rcss_pkg::*;
#(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    localparam logic [CH_W-1:0]   CC4 = CH_W'(CHANNEL_COUNT);
    localparam logic [CH_W:0]     CC5 = (CH_W+1)'(CHANNEL_COUNT);
    localparam logic [BYTE_W-1:0] CC8 = BYTE_W'(CHANNEL_COUNT);
    localparam logic [CNT_W-1:0]  CNT_MAX = '1;

    logic [1:0]       phase_reg, phase_next;
    logic             awaiting_reg, awaiting_next;
    logic [CH_W-1:0]  sweep_reg, sweep_next;
    logic [CH_W-1:0]  start_reg, start_next;
    logic [CH_W-1:0]  hint_reg, hint_next;
    logic [CH_W-1:0]  cur_ch_reg, cur_ch_next;
    logic [CNT_W-1:0] dwell_el_reg, dwell_el_next;
    logic [CNT_W-1:0] probe_el_reg, probe_el_next;
    logic [CNT_W-1:0] limit_reg, limit_next;
    logic             ext_used_reg, ext_used_next;

    // advance() outcome
    logic             adv_fail;
    logic [1:0]       adv_phase;
    logic [CH_W-1:0]  adv_sweep;
    logic [CH_W-1:0]  adv_ch;
    logic [CNT_W-1:0] adv_limit;

    logic [CH_W-1:0]  fast_pos;
    logic [CH_W:0]    fast_sum;
    logic [CH_W:0]    fast_idx;
    logic [CH_W-1:0]  cand0, cand1, cand2;
    logic [CNT_W-1:0] lim_base, lim_double, lim_half;

    logic             active, dwelling;
    logic             hint_ok, rep_ok;
    logic [CNT_W-1:0] de_inc, pe_inc;
    logic [CH_W-1:0]  start_pos;

    assign lim_base   = CNT_W'(cfg.base_dwell);
    assign lim_double = {1'b0, cfg.base_dwell, 1'b0};
    assign lim_half   = lim_base + CNT_W'(cfg.base_dwell[TICK_W-1:1]);

    assign fast_pos = sweep_reg + 1'b1;
    assign fast_sum = {1'b0, start_reg} + {1'b0, fast_pos};
    assign fast_idx = (fast_sum >= CC5) ? fast_sum - CC5 : fast_sum;

    assign cand0 = hint_reg;
    assign cand1 = (hint_reg > 4'd1) ? hint_reg - 1'b1 : hint_reg;
    assign cand2 = (hint_reg < CC4) ? hint_reg + 1'b1 : hint_reg;

    always_comb
    begin
        adv_fail  = 1'b0;
        adv_phase = phase_reg;
        adv_sweep = sweep_reg;
        adv_ch    = '0;
        adv_limit = lim_half;
        if (phase_reg == PH_FAST)
        begin
            adv_sweep = fast_pos;
            if (fast_pos < CC4)
            begin
                adv_ch    = fast_idx[CH_W-1:0] + 1'b1;
                adv_limit = lim_base;
            end
            else if (hint_reg != '0)
            begin
                adv_phase = PH_WEIGHTED;
                adv_sweep = '0;
                adv_ch    = hint_reg;
                adv_limit = lim_double;
            end
            else
            begin
                adv_fail = 1'b1;
            end
        end
        else if (sweep_reg == 4'd0 && cand1 != cand0)
        begin
            adv_sweep = 4'd1;
            adv_ch    = cand1;
        end
        else if ((sweep_reg == 4'd0 || sweep_reg == 4'd1) && cand2 != cand1)
        begin
            adv_sweep = 4'd2;
            adv_ch    = cand2;
        end
        else
        begin
            adv_fail = 1'b1;
        end
    end

    assign active   = (phase_reg == PH_FAST) || (phase_reg == PH_WEIGHTED);
    assign dwelling = active && !awaiting_reg;
    assign hint_ok  = (item.hint_channel >= 8'd1) && (item.hint_channel <= CC8);
    assign rep_ok   = (item.reported_channel >= 8'd1) && (item.reported_channel <= CC8);
    assign de_inc   = (dwell_el_reg < CNT_MAX) ? dwell_el_reg + 1'b1 : dwell_el_reg;
    assign pe_inc   = (probe_el_reg < CNT_MAX) ? probe_el_reg + 1'b1 : probe_el_reg;
    assign start_pos = hint_ok ? item.hint_channel[CH_W-1:0] - 1'b1 : '0;

    always_comb
    begin
        phase_next    = phase_reg;
        awaiting_next = awaiting_reg;
        sweep_next    = sweep_reg;
        start_next    = start_reg;
        hint_next     = hint_reg;
        cur_ch_next   = cur_ch_reg;
        dwell_el_next = dwell_el_reg;
        probe_el_next = probe_el_reg;
        limit_next    = limit_reg;
        ext_used_next = ext_used_reg;
        res           = '0;

        // shared advance step, used by a failed set and by an expired dwell
        if ((item.func == FUNC_SET_RES && active && awaiting_reg && !item.set_ok) ||
            (item.func == FUNC_TICK && dwelling && de_inc >= limit_reg))
        begin
            res.valid = 1'b1;
            if (adv_fail)
            begin
                phase_next    = PH_IDLE;
                awaiting_next = 1'b0;
                res.action    = ACT_FAILED;
                if (item.func == FUNC_TICK)
                begin
                    dwell_el_next = de_inc;
                    probe_el_next = pe_inc;
                end
            end
            else
            begin
                phase_next    = adv_phase;
                sweep_next    = adv_sweep;
                cur_ch_next   = adv_ch;
                limit_next    = adv_limit;
                awaiting_next = 1'b1;
                dwell_el_next = '0;
                probe_el_next = '0;
                ext_used_next = 1'b0;
                res.action    = ACT_SET_CHANNEL;
                res.channel   = adv_ch;
            end
        end
        else
        begin
            case (item.func)
                FUNC_START:
                begin
                    hint_next     = hint_ok ? item.hint_channel[CH_W-1:0] : '0;
                    start_next    = start_pos;
                    phase_next    = PH_FAST;
                    sweep_next    = '0;
                    cur_ch_next   = start_pos + 1'b1;
                    limit_next    = lim_base;
                    awaiting_next = 1'b1;
                    dwell_el_next = '0;
                    probe_el_next = '0;
                    ext_used_next = 1'b0;
                    res.valid     = 1'b1;
                    res.action    = ACT_SET_CHANNEL;
                    res.channel   = start_pos + 1'b1;
                end
                FUNC_SET_RES:
                begin
                    if (active && awaiting_reg)
                    begin
                        awaiting_next = 1'b0;
                        dwell_el_next = '0;
                        probe_el_next = '0;
                        res.valid     = 1'b1;
                        res.action    = ACT_SEND_PROBE;
                        res.channel   = cur_ch_reg;
                    end
                end
                FUNC_TICK:
                begin
                    if (dwelling)
                    begin
                        dwell_el_next = de_inc;
                        probe_el_next = pe_inc;
                        if (pe_inc >= CNT_W'(cfg.probe_interval))
                        begin
                            probe_el_next = '0;
                            res.valid     = 1'b1;
                            res.action    = ACT_SEND_PROBE;
                            res.channel   = cur_ch_reg;
                        end
                    end
                end
                FUNC_MESSAGE:
                begin
                    if (dwelling && item.message_length != '0)
                    begin
                        if (item.message_type == cfg.probe_type_code && !ext_used_reg)
                        begin
                            limit_next    = limit_reg + CNT_W'(cfg.dwell_extension);
                            ext_used_next = 1'b1;
                        end
                        if (item.message_type == cfg.ack_type_code &&
                            item.message_length >= cfg.ack_min_length)
                        begin
                            phase_next       = PH_IDLE;
                            awaiting_next    = 1'b0;
                            res.valid        = 1'b1;
                            res.action       = ACT_FOUND;
                            res.channel      = rep_ok ? item.reported_channel[CH_W-1:0]
                                                      : cur_ch_reg;
                            res.peer_address = item.sender_address;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            awaiting_reg <= 1'b0;
            sweep_reg    <= '0;
            start_reg    <= '0;
            hint_reg     <= '0;
            cur_ch_reg   <= '0;
            dwell_el_reg <= '0;
            probe_el_reg <= '0;
            limit_reg    <= '0;
            ext_used_reg <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            awaiting_reg <= awaiting_next;
            sweep_reg    <= sweep_next;
            start_reg    <= start_next;
            hint_reg     <= hint_next;
            cur_ch_reg   <= cur_ch_next;
            dwell_el_reg <= dwell_el_next;
            probe_el_reg <= probe_el_next;
            limit_reg    <= limit_next;
            ext_used_reg <= ext_used_next;
        end
    end

endmodule
